@@ sv/rtp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared types and constants of the rotation trapezoid profile generator.
// ----------------------------------------------------------------------------
package rtp_pkg;

	localparam logic [30:0] MAX31       = 31'h7FFF_FFFF;
	localparam logic [31:0] DEG2RAD_Q32 = 32'd74961321;
	localparam logic [63:0] HALF_Q32    = 64'h0000_0000_8000_0000;

	// Configuration register indexes.
	localparam logic [2:0] REG_LINEAR_ACCEL      = 3'd0;
	localparam logic [2:0] REG_LINEAR_TOP_SPEED  = 3'd1;
	localparam logic [2:0] REG_LINEAR_DECEL      = 3'd2;
	localparam logic [2:0] REG_LINEAR_MIN_SPEED  = 3'd3;
	localparam logic [2:0] REG_TOLERANCE_DEGREES = 3'd4;
	localparam logic [2:0] REG_WHEEL_BASE        = 3'd5;
	localparam logic [2:0] REG_TICK_PERIOD       = 3'd6;

	// Datapath operations.
	localparam logic [4:0] OP_NONE      = 5'd0;
	localparam logic [4:0] OP_LOAD      = 5'd1;
	localparam logic [4:0] OP_DIV_ACC   = 5'd2;
	localparam logic [4:0] OP_DIV_DEC   = 5'd3;
	localparam logic [4:0] OP_DIV_TOP   = 5'd4;
	localparam logic [4:0] OP_MUL_STEP  = 5'd5;
	localparam logic [4:0] OP_WB_STEP   = 5'd6;
	localparam logic [4:0] OP_MUL_TOP2  = 5'd7;
	localparam logic [4:0] OP_DIV_BD    = 5'd8;
	localparam logic [4:0] OP_MUL_GOAL  = 5'd9;
	localparam logic [4:0] OP_WB_GOAL   = 5'd10;
	localparam logic [4:0] OP_MUL_TOL   = 5'd11;
	localparam logic [4:0] OP_MUL_PROD  = 5'd12;
	localparam logic [4:0] OP_SQRT      = 5'd13;
	localparam logic [4:0] OP_BRAKE     = 5'd14;
	localparam logic [4:0] OP_RAMP      = 5'd15;
	localparam logic [4:0] OP_MUL_WHEEL = 5'd16;
	localparam logic [4:0] OP_OUT_SPEED = 5'd17;
	localparam logic [4:0] OP_OUT_FINAL = 5'd18;

	// Divider destinations.
	localparam logic [1:0] DST_ACC = 2'd0;
	localparam logic [1:0] DST_DEC = 2'd1;
	localparam logic [1:0] DST_TOP = 2'd2;
	localparam logic [1:0] DST_BD  = 2'd3;

	typedef struct packed {
		logic [4:0] op;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic sqrt_busy;
		logic near;
		logic brake;
		logic done;
	} status_t;

endpackage

@@ sv/rtp_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_datapath
// Configuration, profile state, a shared multiplier, a bit-serial divider and
// a bit-serial square root, all driven by operation codes from the controller.
// ----------------------------------------------------------------------------
module rtp_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_wdata,
	input  logic [95:0]        in_data,
	input  rtp_pkg::cmd_t      cmd,
	output rtp_pkg::status_t   status,
	output logic [63:0]        out_data,
	output logic               out_reached
);

	logic [30:0] la_q, lt_q, ld_q, lmin_q, tol_q, wb_q, tp_q;
	logic signed [31:0] goal_q;
	logic        done_q;
	logic [30:0] cr_q, step_q, dec_q, top_q, bd_q, acc_q;

	logic [31:0] target_q, heading_q, rate_q;
	logic [63:0] prod_q, top2_q;
	logic [32:0] dist_q;
	logic        neg_q;
	logic [31:0] cur_q;

	logic [63:0] dvd_q;
	logic [32:0] rem_q;
	logic [31:0] dsr_q;
	logic [5:0]  dcnt_q;
	logic [1:0]  dst_q;
	logic        dbusy_q;

	logic [63:0] rad_q;
	logic [33:0] srem_q;
	logic [31:0] root_q;
	logic [4:0]  scnt_q;
	logic        sbusy_q;

	logic [30:0] wb_eff;
	logic [31:0] mul_a, mul_b;
	logic [31:0] tmag;
	logic [63:0] rnd;
	logic signed [32:0] diff;
	logic [32:0] rem_sh, rem_sub;
	logic [63:0] q_next;
	logic [30:0] q_sat;
	logic [35:0] s_sh, s_trial, s_sub;
	logic [63:0] twoprod;
	logic [31:0] sum;
	logic [31:0] sum_lim;
	logic [46:0] wheel_full;
	logic [30:0] wheel_sat, wheel;

	assign wb_eff = (wb_q == 31'd0) ? 31'd1 : wb_q;
	assign tmag   = target_q[31] ? (32'd0 - target_q) : target_q;
	assign rnd    = prod_q + rtp_pkg::HALF_Q32;
	assign diff   = {goal_q[31], goal_q} - {heading_q[31], heading_q};

	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (cmd.op)
			rtp_pkg::OP_MUL_STEP: begin
				mul_a = {1'b0, acc_q};
				mul_b = {1'b0, tp_q};
			end
			rtp_pkg::OP_MUL_TOP2: begin
				mul_a = {1'b0, top_q};
				mul_b = {1'b0, top_q};
			end
			rtp_pkg::OP_MUL_GOAL: begin
				mul_a = tmag;
				mul_b = rtp_pkg::DEG2RAD_Q32;
			end
			rtp_pkg::OP_MUL_TOL: begin
				mul_a = {1'b0, tol_q};
				mul_b = rtp_pkg::DEG2RAD_Q32;
			end
			rtp_pkg::OP_MUL_PROD: begin
				mul_a = {1'b0, dec_q};
				mul_b = {1'b0, bd_q} - dist_q[31:0];
			end
			rtp_pkg::OP_MUL_WHEEL: begin
				mul_a = {1'b0, cr_q};
				mul_b = {1'b0, wb_eff};
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	// One restoring divider step: the quotient bits shift in behind the dividend.
	assign rem_sh  = {rem_q[31:0], dvd_q[63]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};
	assign q_next  = (rem_sh >= {1'b0, dsr_q}) ? {dvd_q[62:0], 1'b1} : {dvd_q[62:0], 1'b0};
	assign q_sat   = (q_next > {33'd0, rtp_pkg::MAX31}) ? rtp_pkg::MAX31 : q_next[30:0];

	// One square-root step, two radicand bits at a time.
	assign s_sh    = {srem_q, rad_q[63:62]};
	assign s_trial = {2'b00, root_q, 2'b01};
	assign s_sub   = s_sh - s_trial;

	assign twoprod = {prod_q[62:0], 1'b0};
	assign sum     = {1'b0, cr_q} + {1'b0, step_q};
	assign sum_lim = (sum > root_q) ? root_q : sum;

	assign wheel_full = prod_q[63:17];
	assign wheel_sat  = (wheel_full > {16'd0, rtp_pkg::MAX31}) ? rtp_pkg::MAX31
		: wheel_full[30:0];
	assign wheel      = (wheel_sat < lmin_q) ? lmin_q : wheel_sat;

	assign status.div_busy  = dbusy_q;
	assign status.sqrt_busy = sbusy_q;
	assign status.near      = (dist_q <= {1'b0, rnd[63:32]});
	assign status.brake     = (dist_q < {2'b00, bd_q});
	assign status.done      = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			la_q    <= 31'd0;
			lt_q    <= 31'd0;
			ld_q    <= 31'd65536;
			lmin_q  <= 31'd0;
			tol_q   <= 31'd0;
			wb_q    <= 31'd65536;
			tp_q    <= 31'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				rtp_pkg::REG_LINEAR_ACCEL:      la_q   <= cfg_wdata;
				rtp_pkg::REG_LINEAR_TOP_SPEED:  lt_q   <= cfg_wdata;
				rtp_pkg::REG_LINEAR_DECEL:      ld_q   <= cfg_wdata;
				rtp_pkg::REG_LINEAR_MIN_SPEED:  lmin_q <= cfg_wdata;
				rtp_pkg::REG_TOLERANCE_DEGREES: tol_q  <= cfg_wdata;
				rtp_pkg::REG_WHEEL_BASE:        wb_q   <= cfg_wdata;
				rtp_pkg::REG_TICK_PERIOD:       tp_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q  <= 32'sd0;
			done_q  <= 1'b1;
			cr_q    <= 31'd0;
			step_q  <= 31'd0;
			dec_q   <= 31'd0;
			top_q   <= 31'd0;
			bd_q    <= 31'd0;
			dbusy_q <= 1'b0;
			sbusy_q <= 1'b0;
		end else begin
			if (dbusy_q) begin
				rem_q  <= (rem_sh >= {1'b0, dsr_q}) ? rem_sub : rem_sh;
				dvd_q  <= q_next;
				dcnt_q <= dcnt_q + 6'd1;
				if (dcnt_q == 6'd63) begin
					dbusy_q <= 1'b0;
					case (dst_q)
						rtp_pkg::DST_ACC: acc_q <= q_sat;
						rtp_pkg::DST_DEC: dec_q <= q_sat;
						rtp_pkg::DST_TOP: top_q <= q_sat;
						default:          bd_q  <= q_sat;
					endcase
				end
			end
			if (sbusy_q) begin
				rad_q  <= {rad_q[61:0], 2'b00};
				scnt_q <= scnt_q + 5'd1;
				if (s_sh >= s_trial) begin
					srem_q <= s_sub[33:0];
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					srem_q <= s_sh[33:0];
					root_q <= {root_q[30:0], 1'b0};
				end
				if (scnt_q == 5'd31) begin
					sbusy_q <= 1'b0;
				end
			end
			case (cmd.op)
				rtp_pkg::OP_LOAD: begin
					target_q  <= in_data[31:0];
					heading_q <= in_data[63:32];
					rate_q    <= in_data[95:64];
				end
				rtp_pkg::OP_DIV_ACC, rtp_pkg::OP_DIV_DEC, rtp_pkg::OP_DIV_TOP: begin
					case (cmd.op)
						rtp_pkg::OP_DIV_ACC: begin
							dvd_q <= {16'd0, la_q, 17'd0};
							dst_q <= rtp_pkg::DST_ACC;
						end
						rtp_pkg::OP_DIV_DEC: begin
							dvd_q <= {16'd0, ld_q, 17'd0};
							dst_q <= rtp_pkg::DST_DEC;
						end
						default: begin
							dvd_q <= {16'd0, lt_q, 17'd0};
							dst_q <= rtp_pkg::DST_TOP;
						end
					endcase
					dsr_q   <= {1'b0, wb_eff};
					rem_q   <= 33'd0;
					dcnt_q  <= 6'd0;
					dbusy_q <= 1'b1;
				end
				rtp_pkg::OP_DIV_BD: begin
					if (dec_q == 31'd0) begin
						bd_q <= rtp_pkg::MAX31;
					end else begin
						dvd_q   <= prod_q;
						dsr_q   <= {dec_q, 1'b0};
						dst_q   <= rtp_pkg::DST_BD;
						rem_q   <= 33'd0;
						dcnt_q  <= 6'd0;
						dbusy_q <= 1'b1;
					end
				end
				rtp_pkg::OP_MUL_STEP, rtp_pkg::OP_MUL_TOP2, rtp_pkg::OP_MUL_GOAL,
				rtp_pkg::OP_MUL_WHEEL: begin
					prod_q <= mul_a * mul_b;
				end
				rtp_pkg::OP_MUL_TOL: begin
					prod_q <= mul_a * mul_b;
					neg_q  <= diff[32];
					dist_q <= diff[32] ? (33'd0 - diff) : diff;
					cur_q  <= rate_q[31] ? (32'd0 - rate_q) : rate_q;
				end
				rtp_pkg::OP_MUL_PROD: begin
					top2_q <= prod_q;
					prod_q <= mul_a * mul_b;
				end
				rtp_pkg::OP_WB_STEP: begin
					step_q <= (prod_q[63:16] > {17'd0, rtp_pkg::MAX31}) ? rtp_pkg::MAX31
						: prod_q[46:16];
				end
				rtp_pkg::OP_WB_GOAL: begin
					goal_q <= target_q[31] ? (32'sd0 - rnd[63:32]) : rnd[63:32];
					done_q <= 1'b0;
				end
				rtp_pkg::OP_SQRT: begin
					rad_q   <= (top2_q > twoprod) ? (top2_q - twoprod) : 64'd0;
					srem_q  <= 34'd0;
					root_q  <= 32'd0;
					scnt_q  <= 5'd0;
					sbusy_q <= 1'b1;
				end
				rtp_pkg::OP_BRAKE: begin
					if (root_q > cur_q) begin
						cr_q <= (sum_lim > {1'b0, top_q}) ? top_q : sum_lim[30:0];
					end else begin
						cr_q <= root_q[30:0];
					end
				end
				rtp_pkg::OP_RAMP: begin
					if (cr_q < top_q) begin
						cr_q <= (sum > {1'b0, top_q}) ? top_q : sum[30:0];
					end
				end
				rtp_pkg::OP_OUT_SPEED: begin
					out_data[31:0]  <= neg_q ? {1'b0, wheel} : (32'd0 - {1'b0, wheel});
					out_data[63:32] <= neg_q ? (32'd0 - {1'b0, wheel}) : {1'b0, wheel};
					out_reached     <= 1'b0;
				end
				rtp_pkg::OP_OUT_FINAL: begin
					out_data    <= 64'd0;
					out_reached <= 1'b1;
					done_q      <= 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

@@ sv/rtp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_ctrl
// Sequencer for start and tick items, plus the output valid flag.
// ----------------------------------------------------------------------------
module rtp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_kind,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  rtp_pkg::status_t  status,
	output rtp_pkg::cmd_t     cmd
);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_DA    = 5'd1;
	localparam logic [4:0] ST_DA_W  = 5'd2;
	localparam logic [4:0] ST_DD    = 5'd3;
	localparam logic [4:0] ST_DD_W  = 5'd4;
	localparam logic [4:0] ST_DT    = 5'd5;
	localparam logic [4:0] ST_DT_W  = 5'd6;
	localparam logic [4:0] ST_MS    = 5'd7;
	localparam logic [4:0] ST_WS    = 5'd8;
	localparam logic [4:0] ST_MT    = 5'd9;
	localparam logic [4:0] ST_DB    = 5'd10;
	localparam logic [4:0] ST_DB_W  = 5'd11;
	localparam logic [4:0] ST_MG    = 5'd12;
	localparam logic [4:0] ST_WG    = 5'd13;
	localparam logic [4:0] ST_MTOL  = 5'd14;
	localparam logic [4:0] ST_CHK   = 5'd15;
	localparam logic [4:0] ST_FIN   = 5'd16;
	localparam logic [4:0] ST_MT2   = 5'd17;
	localparam logic [4:0] ST_MP    = 5'd18;
	localparam logic [4:0] ST_SQ    = 5'd19;
	localparam logic [4:0] ST_SQ_W  = 5'd20;
	localparam logic [4:0] ST_BRAKE = 5'd21;
	localparam logic [4:0] ST_RAMP  = 5'd22;
	localparam logic [4:0] ST_MW    = 5'd23;
	localparam logic [4:0] ST_OUT   = 5'd24;

	logic [4:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       issue;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd.op  = rtp_pkg::OP_NONE;
		issue   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op = rtp_pkg::OP_LOAD;
					if (!in_kind) begin
						state_d = ST_DA;
					end else if (!status.done) begin
						state_d = ST_MTOL;
					end
				end
			end
			ST_DA: begin
				cmd.op  = rtp_pkg::OP_DIV_ACC;
				state_d = ST_DA_W;
			end
			ST_DA_W: if (!status.div_busy) state_d = ST_DD;
			ST_DD: begin
				cmd.op  = rtp_pkg::OP_DIV_DEC;
				state_d = ST_DD_W;
			end
			ST_DD_W: if (!status.div_busy) state_d = ST_DT;
			ST_DT: begin
				cmd.op  = rtp_pkg::OP_DIV_TOP;
				state_d = ST_DT_W;
			end
			ST_DT_W: if (!status.div_busy) state_d = ST_MS;
			ST_MS: begin
				cmd.op  = rtp_pkg::OP_MUL_STEP;
				state_d = ST_WS;
			end
			ST_WS: begin
				cmd.op  = rtp_pkg::OP_WB_STEP;
				state_d = ST_MT;
			end
			ST_MT: begin
				cmd.op  = rtp_pkg::OP_MUL_TOP2;
				state_d = ST_DB;
			end
			ST_DB: begin
				cmd.op  = rtp_pkg::OP_DIV_BD;
				state_d = ST_DB_W;
			end
			ST_DB_W: if (!status.div_busy) state_d = ST_MG;
			ST_MG: begin
				cmd.op  = rtp_pkg::OP_MUL_GOAL;
				state_d = ST_WG;
			end
			ST_WG: begin
				cmd.op  = rtp_pkg::OP_WB_GOAL;
				state_d = ST_IDLE;
			end
			ST_MTOL: begin
				cmd.op  = rtp_pkg::OP_MUL_TOL;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (status.near) begin
					state_d = ST_FIN;
				end else if (status.brake) begin
					state_d = ST_MT2;
				end else begin
					state_d = ST_RAMP;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.op  = rtp_pkg::OP_OUT_FINAL;
					issue   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_MT2: begin
				cmd.op  = rtp_pkg::OP_MUL_TOP2;
				state_d = ST_MP;
			end
			ST_MP: begin
				cmd.op  = rtp_pkg::OP_MUL_PROD;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.op  = rtp_pkg::OP_SQRT;
				state_d = ST_SQ_W;
			end
			ST_SQ_W: if (!status.sqrt_busy) state_d = ST_BRAKE;
			ST_BRAKE: begin
				cmd.op  = rtp_pkg::OP_BRAKE;
				state_d = ST_MW;
			end
			ST_RAMP: begin
				cmd.op  = rtp_pkg::OP_RAMP;
				state_d = ST_MW;
			end
			ST_MW: begin
				cmd.op  = rtp_pkg::OP_MUL_WHEEL;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.op  = rtp_pkg::OP_OUT_SPEED;
					issue   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ sv/rotation_trapezoid_profile.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_trapezoid_profile
// Turn-in-place trapezoidal rate profile generator for a two-wheel robot.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A start item (tuser low) runs up to four
// bit-serial divisions (the fourth is skipped when the angular deceleration
// is zero) and three multiplies, and gives no transfer. A tick runs the
// ramp path, or inside the braking distance also the 32-step square root;
// a tick while idle is only loaded and gives no transfer. The result sits in an
// output register, so a new item is taken while the previous transfer still
// waits.
module rotation_trapezoid_profile (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // target_degrees, measured_heading, measured_rate
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // left_speed, right_speed
	output logic        m_tuser   // reached
);

	rtp_pkg::cmd_t    cmd;
	rtp_pkg::status_t status;

	rtp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_kind   (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	rtp_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_data     (s_tdata),
		.cmd         (cmd),
		.status      (status),
		.out_data    (m_tdata),
		.out_reached (m_tuser)
	);

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the rotation trapezoid profile generator.
// ----------------------------------------------------------------------------
// A predictor in the testbench models the generator in Q16.16. It follows the
// start and tick items and keeps a queue of expected wheel commands, which are
// compared with each output transfer. Both stream sides stall at random. The
// run covers directed corner cases and then random moves under several
// register settings.
module testbench;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_TICK  = 1'b1;
	localparam int   SETTLE     = 400;

	typedef struct packed {
		logic [31:0] left;
		logic [31:0] right;
		logic        reached;
	} wheel_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = rtp_pkg::REG_LINEAR_ACCEL;
	logic [30:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;  // target_degrees, measured_heading, measured_rate
	logic        s_tuser = 1'b0;  // kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;  // left_speed, right_speed
	logic        m_tuser;  // reached

	rotation_trapezoid_profile i_dut (.*);

	initial forever #5 clk = ~clk;

	// Register copies.
	logic [30:0] reg_accel = 31'd0, lin_top = 31'd0, reg_decel = 31'd65536, lin_min = 31'd0;
	logic [30:0] tol_deg = 31'd0, base_len = 31'd65536, period = 31'd0;
	// Profile state.
	logic [31:0] goal = 0;
	logic        idle = 1'b1;
	logic [63:0] cmd_rate = 0, step = 0, ang_decel = 0, ang_top = 0, brake_dist = 0;

	wheel_cmd_t expected_cmds[$];
	int         failures = 0;
	bit         calm = 1'b0;

	function automatic logic [63:0] sat31(input logic [63:0] v);
		return (v > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : v;
	endfunction

	function automatic logic [63:0] deg_to_rad(input logic [63:0] mag);
		return (mag * 64'd74961321 + 64'h8000_0000) >> 32;
	endfunction

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] res, bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v) bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v = v - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] base_nz();
		return (base_len == 0) ? 64'd1 : {33'd0, base_len};
	endfunction

	// Updates the profile state for one accepted item and queues any result.
	task automatic predict_item(input logic kind, input logic [31:0] tgt,
			input logic [31:0] hdg, input logic [31:0] rate);
		logic [63:0] acc, mag, g, gap, tol, cur, cr, top2, prod, want, wheel;
		logic signed [63:0] ts, diff, rs, sp;
		logic        neg;
		wheel_cmd_t  cmd;
		if (kind == KIND_START) begin
			acc = sat31(({33'd0, reg_accel} << 17) / base_nz());
			ts = $signed(tgt);
			mag = (ts < 0) ? -ts : ts;
			g = deg_to_rad(mag);
			ang_decel = sat31(({33'd0, reg_decel} << 17) / base_nz());
			ang_top = sat31(({33'd0, lin_top} << 17) / base_nz());
			step = sat31((acc * {33'd0, period}) >> 16);
			if (ang_decel == 0)
				brake_dist = 64'h7FFF_FFFF;
			else
				brake_dist = sat31((ang_top * ang_top) / (2 * ang_decel));
			goal = (ts < 0) ? -g[31:0] : g[31:0];
			idle = 1'b0;
			return;
		end
		if (idle) return;
		diff = $signed({{32{goal[31]}}, goal}) - $signed({{32{hdg[31]}}, hdg});
		neg = diff < 0;
		gap = neg ? -diff : diff;
		tol = deg_to_rad({33'd0, tol_deg});
		rs = $signed({{32{rate[31]}}, rate});
		cur = (rs < 0) ? -rs : rs;
		cr = cmd_rate;
		if (gap <= tol) begin
			cmd = '{left: 32'd0, right: 32'd0, reached: 1'b1};
			expected_cmds.push_back(cmd);
			idle = 1'b1;
			return;
		end
		if (gap < brake_dist) begin
			top2 = ang_top * ang_top;
			prod = 2 * ang_decel * (brake_dist - gap);
			want = isqrt((top2 > prod) ? top2 - prod : 0);
			if (want > cur) begin
				cr = cr + step;
				if (cr > want) cr = want;
				if (cr > ang_top) cr = ang_top;
			end else begin
				cr = want;
			end
		end else if (cr < ang_top) begin
			cr = cr + step;
			if (cr > ang_top) cr = ang_top;
		end
		cmd_rate = sat31(cr);
		wheel = sat31((cmd_rate * base_nz()) >> 17);
		if (wheel < {33'd0, lin_min}) wheel = {33'd0, lin_min};
		sp = neg ? -$signed(wheel) : $signed(wheel);
		cmd.left = -sp[31:0];
		cmd.right = sp[31:0];
		cmd.reached = 1'b0;
		expected_cmds.push_back(cmd);
	endtask

	// Sends one item and predicts its effect at the edge of its transfer.
	task automatic send_item(input logic kind, input logic [31:0] tgt,
			input logic [31:0] hdg, input logic [31:0] rate);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {rate, hdg, tgt};
		do @(posedge clk); while (!s_tready);
		predict_item(kind, tgt, hdg, rate);
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_cmds.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [30:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
	endtask

	task automatic write_regs(input logic [30:0] acc, input logic [30:0] top,
			input logic [30:0] dec, input logic [30:0] mn, input logic [30:0] tol,
			input logic [30:0] wb, input logic [30:0] per);
		write_reg(rtp_pkg::REG_LINEAR_ACCEL, acc);
		write_reg(rtp_pkg::REG_LINEAR_TOP_SPEED, top);
		write_reg(rtp_pkg::REG_LINEAR_DECEL, dec);
		write_reg(rtp_pkg::REG_LINEAR_MIN_SPEED, mn);
		write_reg(rtp_pkg::REG_TOLERANCE_DEGREES, tol);
		write_reg(rtp_pkg::REG_WHEEL_BASE, wb);
		write_reg(rtp_pkg::REG_TICK_PERIOD, per);
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_accel = acc; lin_top = top; reg_decel = dec; lin_min = mn;
		tol_deg = tol; base_len = wb; period = per;
	endtask

	// One move: a start, then ticks closing on the goal with some overshoot.
	task automatic run_move(input logic [31:0] tgt, input int ticks, input int span);
		int          off;
		logic [31:0] hdg, rate;
		send_item(KIND_START, tgt, $urandom, $urandom);
		for (int k = 0; k < ticks; k++) begin
			off = (span / ticks) * (ticks - 1 - k) + $urandom_range(span / ticks);
			if ($urandom_range(9) == 0) off = -off;
			hdg = goal - off;
			rate = ($urandom_range(3) == 0) ? $urandom : $urandom_range(300000);
			if ($urandom_range(1)) rate = -rate;
			send_item(KIND_TICK, $urandom, hdg, rate);
		end
	endtask

	task automatic test_directed();
		// Ticks while idle after reset.
		send_item(KIND_TICK, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		send_item(KIND_TICK, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
		settle();
		write_regs(31'd32768, 31'd19661, 31'd32768, 31'd0, 31'd65536, 31'd13107, 31'd655);
		send_item(KIND_START, 32'h7FFF_FFFF, 0, 0);
		send_item(KIND_TICK, 0, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(KIND_TICK, 0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_item(KIND_TICK, 0, goal, 0);
		send_item(KIND_TICK, 0, goal, 0);
		send_item(KIND_START, 32'h8000_0000, 0, 0);
		send_item(KIND_TICK, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_item(KIND_TICK, 0, goal + 32'd20000, 32'd0);
		send_item(KIND_TICK, 0, goal - 32'd20000, 32'd1000);
		send_item(KIND_TICK, 0, goal + 32'd1000, 32'd0);
		send_item(KIND_START, 32'h0, 0, 0);
		send_item(KIND_TICK, 0, 32'd0, 32'd0);
		settle();
		// Zero wheel base and tolerance, a deceleration of one, other limits at full scale.
		write_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF, 31'h0, 31'h0,
			31'h7FFF_FFFF);
		send_item(KIND_START, 32'd5898240, 0, 0);
		send_item(KIND_TICK, 0, 32'd0, 32'd0);
		send_item(KIND_TICK, 0, 32'h8000_0000, 32'd0);
		send_item(KIND_TICK, 0, goal, 32'd0);
		settle();
		// A deceleration too small to leave the angular value nonzero.
		write_regs(31'd1, 31'd1, 31'd1, 31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1);
		send_item(KIND_START, 32'd65536, 0, 0);
		send_item(KIND_TICK, 0, 32'h8000_0000, 32'd0);
		send_item(KIND_TICK, 0, 32'h7FFF_FFFF, 32'd0);
		settle();
	endtask

	task automatic test_random_moves(input int items);
		int sent;
		int ticks;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(9) == 0) begin
				send_item(1'($urandom_range(1)), $urandom, $urandom, $urandom);
				sent++;
			end else begin
				ticks = $urandom_range(4, 16);
				run_move(($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 23592960)
					- 32'd11796480, ticks, $urandom_range(20000, 200000));
				sent += ticks + 1;
			end
		end
		settle();
	endtask

	task automatic test_settings();
		write_regs(31'd32768, 31'd19661, 31'd32768, 31'd3000, 31'd65536, 31'd13107, 31'd655);
		calm = 1'b1;
		test_random_moves(80);
		calm = 1'b0;
		test_random_moves(80);
		write_regs(31'd65536, 31'd65536, 31'd131072, 31'd0, 31'd32768, 31'd32768, 31'd3277);
		test_random_moves(90);
		write_regs(31'($urandom), 31'($urandom), 31'($urandom | 32'd1),
			31'($urandom_range(5000)), 31'($urandom), 31'($urandom | 32'd1),
			31'($urandom));
		test_random_moves(80);
		write_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0, 31'd0, 31'd1,
			31'h7FFF_FFFF);
		test_random_moves(80);
		write_regs(31'($urandom_range(200000)), 31'($urandom_range(200000)),
			31'($urandom_range(1, 200000)), 31'($urandom_range(20000)),
			31'($urandom_range(200000)), 31'($urandom_range(1, 65536)),
			31'($urandom_range(6554)));
		test_random_moves(90);
	endtask

	always @(negedge clk)
		m_tready <= (calm || $urandom_range(99) >= 30);

	always @(posedge clk) begin
		wheel_cmd_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_cmds.size() == 0) begin
				$error("unexpected transfer: left %h right %h reached %b",
					m_tdata[31:0], m_tdata[63:32], m_tuser);
				failures++;
			end else begin
				want = expected_cmds.pop_front();
				if (m_tdata[31:0] !== want.left) begin
					$error("left_speed expected %h actual %h", want.left, m_tdata[31:0]);
					failures++;
				end
				if (m_tdata[63:32] !== want.right) begin
					$error("right_speed expected %h actual %h", want.right, m_tdata[63:32]);
					failures++;
				end
				if (m_tuser !== want.reached) begin
					$error("reached expected %b actual %b", want.reached, m_tuser);
					failures++;
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE) @(posedge clk);
		test_directed();
		test_settings();
		if (failures == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#10ms;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
